@@ src/dcb_pkg.sv @@
// ----------------------------------------------------------------------------
// dcb_pkg
// Shared types and constants of the DMA descriptor chain builder.
// ----------------------------------------------------------------------------
`default_nettype none

package dcb_pkg;

  // Default build values
  localparam int unsigned BLOCK_ITEMS_DEF = 4194303;
  localparam int unsigned MAX_DESC_DEF    = 5;
  localparam int unsigned DESC_BYTES_DEF  = 64;

  // Field widths
  localparam int unsigned ADDR_IN_W = 32;
  localparam int unsigned ADDR_W    = 40;
  localparam int unsigned ITEM_W    = 25;
  localparam int unsigned CTL_W     = 32;
  localparam int unsigned WCODE_W   = 3;
  localparam int unsigned BSM_W     = 22;
  localparam int unsigned PTR_W     = 32;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned IN_DATA_W  = 160;
  localparam int unsigned OUT_DATA_W = 200;

  // Control word bits
  localparam int unsigned SRC_FIX_BIT = 4;
  localparam int unsigned DST_FIX_BIT = 6;
  localparam logic [CTL_W-1:0] CTL_HI_VALID = 32'h8000_0000;
  localparam logic [CTL_W-1:0] CTL_HI_LAST  = 32'h4000_0000;

  // Register index (word address bit 2)
  localparam logic REG_LIST_BASE = 1'b0;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_TOO_MANY = 2'd1,
    STATUS_ZERO     = 2'd2
  } status_e;

  // Input item, last field (src_addr) in the lowest bits
  typedef struct packed {
    logic [WCODE_W-1:0]   width_code;
    logic [CTL_W-1:0]     ctl_high;
    logic [CTL_W-1:0]     ctl_low;
    logic [ITEM_W-1:0]    item_count;
    logic [ADDR_IN_W-1:0] dst_addr;
    logic [ADDR_IN_W-1:0] src_addr;
  } in_item_t;

  // Result data word, last field (desc_src) in the lowest bits
  typedef struct packed {
    logic [1:0]        pad;
    logic [PTR_W-1:0]  next_ptr;
    logic [BSM_W-1:0]  block_size_m1;
    logic [CTL_W-1:0]  desc_ctl_high;
    logic [CTL_W-1:0]  desc_ctl_low;
    logic [ADDR_W-1:0] desc_dst;
    logic [ADDR_W-1:0] desc_src;
  } out_data_t;

  // Sequencer commands to the step unit
  typedef struct packed {
    logic load;
    logic advance;
  } dcb_ctrl_t;

  // Step unit view of the current descriptor
  typedef struct packed {
    logic              zero;
    logic              too_many;
    logic              last;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [BSM_W-1:0]  bsm1;
    logic [PTR_W-1:0]  nxt;
  } dcb_step_t;

endpackage

`default_nettype wire

@@ src/dcb_step_unit.sv @@
// ----------------------------------------------------------------------------
// dcb_step_unit
// Working registers and the adders that advance one descriptor a step.
// ----------------------------------------------------------------------------
`default_nettype none

module dcb_step_unit import dcb_pkg::*; #(
  parameter int unsigned BLOCK_ITEMS = BLOCK_ITEMS_DEF,
  parameter int unsigned MAX_DESC    = MAX_DESC_DEF,
  parameter int unsigned DESC_BYTES  = DESC_BYTES_DEF
) (
  input  wire logic                 clk_i,
  input  wire dcb_ctrl_t            ctrl_i,
  input  wire logic [ADDR_IN_W-1:0] src_i,
  input  wire logic [ADDR_IN_W-1:0] dst_i,
  input  wire logic [ITEM_W-1:0]    count_i,
  input  wire logic                 fix_src_i,
  input  wire logic                 fix_dst_i,
  input  wire logic [WCODE_W-1:0]   width_code_i,
  input  wire logic [PTR_W-1:0]     list_base_i,
  output dcb_step_t                 step_o
);

  localparam int unsigned BLK_W  = $clog2(BLOCK_ITEMS + 1);
  localparam int unsigned STEP_W = BLK_W + (1 << WCODE_W) - 1;
  localparam logic [ITEM_W-1:0] BLK_ITEMS = ITEM_W'(BLOCK_ITEMS);
  localparam logic [BSM_W-1:0]  FULL_BSM1 = BSM_W'(BLOCK_ITEMS - 1);
  localparam logic [31:0]       MAX_TOTAL = 32'(MAX_DESC * BLOCK_ITEMS);
  localparam logic [PTR_W-1:0]  DESC_INC  = PTR_W'(DESC_BYTES);

  logic [ADDR_W-1:0] src_q, src_d;
  logic [ADDR_W-1:0] dst_q, dst_d;
  logic [STEP_W-1:0] sstep_q, sstep_d;
  logic [STEP_W-1:0] dstep_q, dstep_d;
  logic [ITEM_W-1:0] rem_q, rem_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [STEP_W-1:0] blk_step;
  logic [PTR_W-1:0]  ptr_next;
  logic              is_last;

  // Address step of one full block for this width
  assign blk_step = STEP_W'(BLOCK_ITEMS) << width_code_i;

  assign ptr_next = ptr_q + DESC_INC;
  assign is_last  = (rem_q <= BLK_ITEMS);

  // Load a fresh request or advance by one block
  always_comb begin
    src_d   = src_q;
    dst_d   = dst_q;
    sstep_d = sstep_q;
    dstep_d = dstep_q;
    rem_d   = rem_q;
    ptr_d   = ptr_q;
    if (ctrl_i.load) begin
      src_d   = {{(ADDR_W-ADDR_IN_W){1'b0}}, src_i};
      dst_d   = {{(ADDR_W-ADDR_IN_W){1'b0}}, dst_i};
      sstep_d = fix_src_i ? '0 : blk_step;
      dstep_d = fix_dst_i ? '0 : blk_step;
      rem_d   = count_i;
      ptr_d   = list_base_i;
    end else if (ctrl_i.advance) begin
      src_d   = src_q + {{(ADDR_W-STEP_W){1'b0}}, sstep_q};
      dst_d   = dst_q + {{(ADDR_W-STEP_W){1'b0}}, dstep_q};
      rem_d   = rem_q - BLK_ITEMS;
      ptr_d   = ptr_next;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q   <= src_d;
    dst_q   <= dst_d;
    sstep_q <= sstep_d;
    dstep_q <= dstep_d;
    rem_q   <= rem_d;
    ptr_q   <= ptr_d;
  end

  // Current descriptor and request checks
  always_comb begin
    step_o.zero     = (rem_q == '0);
    step_o.too_many = ({{(32-ITEM_W){1'b0}}, rem_q} > MAX_TOTAL);
    step_o.last     = is_last;
    step_o.src      = src_q;
    step_o.dst      = dst_q;
    step_o.bsm1     = is_last ? BSM_W'(rem_q - ITEM_W'(1)) : FULL_BSM1;
    step_o.nxt      = is_last ? '0 : ptr_next;
  end

endmodule

`default_nettype wire

@@ src/dma_descriptor_chain_builder.sv @@
// ----------------------------------------------------------------------------
// dma_descriptor_chain_builder
// Splits one transfer request into a chain of linked-list descriptors.
// ----------------------------------------------------------------------------
// Sequence: an accepted item loads the step unit, ST_CHECK tests the request and
//   registers an error result, and ST_EMIT registers the descriptors in turn.
// The single step unit produces one descriptor per cycle while the output slot
//   is free; a stalled descriptor stream holds the chain.
// Input is not ready while a request is being split.
// Reset returns the sequencer to idle and clears the output valid and list_base to zero.
`default_nettype none

module dma_descriptor_chain_builder import dcb_pkg::*; #(
  parameter int unsigned BLOCK_ITEMS = BLOCK_ITEMS_DEF,
  parameter int unsigned MAX_DESC    = MAX_DESC_DEF,
  parameter int unsigned DESC_BYTES  = DESC_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // APB configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [2:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic      [31:0]           prdata,
  output logic                       pready,
  // Request stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // tdata: src_addr, dst_addr, item_count, ctl_low, ctl_high, width_code
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // Descriptor stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata: desc_src, desc_dst, desc_ctl_low, desc_ctl_high, block_size_m1,
  //        next_ptr
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast,
  // tuser: status
  output logic [STAT_W-1:0]          m_axis_tuser
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CHECK = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  in_item_t          in_item;
  dcb_ctrl_t         ctrl;
  dcb_step_t         step;
  logic [PTR_W-1:0]  list_base_q;
  logic [CTL_W-1:0]  ctl_low_q, ctl_high_q;
  logic              out_valid_q, out_valid_d;
  out_data_t         out_data_q, out_data_d;
  logic              out_last_q, out_last_d;
  status_e           out_status_q, out_status_d;
  logic              slot_free;
  logic              in_fire;
  logic              cfg_write;

  // Configuration register
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign prdata    = (paddr[2] == REG_LIST_BASE) ? list_base_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_base_q <= '0;
    end else if (cfg_write && (paddr[2] == REG_LIST_BASE)) begin
      list_base_q <= pwdata;
    end
  end

  // Request intake
  assign in_item       = in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ctl_low_q  <= in_item.ctl_low;
      ctl_high_q <= in_item.ctl_high;
    end
  end

  dcb_step_unit #(
    .BLOCK_ITEMS (BLOCK_ITEMS),
    .MAX_DESC    (MAX_DESC),
    .DESC_BYTES  (DESC_BYTES)
  ) u_step (
    .clk_i        (clk_i),
    .ctrl_i       (ctrl),
    .src_i        (in_item.src_addr),
    .dst_i        (in_item.dst_addr),
    .count_i      (in_item.item_count),
    .fix_src_i    (in_item.ctl_low[SRC_FIX_BIT]),
    .fix_dst_i    (in_item.ctl_low[DST_FIX_BIT]),
    .width_code_i (in_item.width_code),
    .list_base_i  (list_base_q),
    .step_o       (step)
  );

  assign slot_free = !out_valid_q || m_axis_tready;

  // Sequencer: check the request, then emit one descriptor per free slot
  always_comb begin
    state_d      = state_q;
    ctrl.load    = 1'b0;
    ctrl.advance = 1'b0;
    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_data_d   = out_data_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ctrl.load = 1'b1;
          state_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (step.zero || step.too_many) begin
          if (slot_free) begin
            out_valid_d  = 1'b1;
            out_data_d   = '0;
            out_last_d   = 1'b1;
            out_status_d = step.zero ? STATUS_ZERO : STATUS_TOO_MANY;
            state_d      = ST_IDLE;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ctrl.advance             = 1'b1;
          out_valid_d              = 1'b1;
          out_data_d.pad           = '0;
          out_data_d.desc_src      = step.src;
          out_data_d.desc_dst      = step.dst;
          out_data_d.desc_ctl_low  = ctl_low_q;
          out_data_d.desc_ctl_high = ctl_high_q | CTL_HI_VALID |
                                     (step.last ? CTL_HI_LAST : '0);
          out_data_d.block_size_m1 = step.bsm1;
          out_data_d.next_ptr      = step.nxt;
          out_last_d               = step.last;
          out_status_d             = STATUS_OK;
          if (step.last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q   <= out_data_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

  // A descriptor that is not the last means more of the chain is pending
  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tlast) |-> (state_q == ST_EMIT))
    else $error("non-last descriptor without chain in progress");

  // Error results always close the request
  a_error_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status_q != STATUS_OK)) |-> m_axis_tlast)
    else $error("error result not marked last");

  // Last good descriptor carries a null next pointer and the last flag
  a_last_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast && (out_status_q == STATUS_OK)) |->
      ((out_data_q.next_ptr == '0) && out_data_q.desc_ctl_high[30]))
    else $error("last descriptor malformed");

  // Emission only runs on a request that passed the checks
  a_emit_checked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!step.zero && !step.too_many))
    else $error("emitting an invalid request");

endmodule

`default_nettype wire

@@ tb/dcb_chain_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcb_chain_checker
// Watches the request, descriptor and register channels of the descriptor
// chain builder, predicts every descriptor of each accepted request and
// compares the descriptor stream against the prediction in order.
// ----------------------------------------------------------------------------

module dcb_chain_checker import dcb_pkg::*; #(
  parameter int unsigned BLOCK_ITEMS = BLOCK_ITEMS_DEF,
  parameter int unsigned MAX_DESC    = MAX_DESC_DEF,
  parameter int unsigned DESC_BYTES  = DESC_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Register port
  input  wire logic                  psel_i,
  input  wire logic                  penable_i,
  input  wire logic                  pwrite_i,
  input  wire logic [2:0]            paddr_i,
  input  wire logic [31:0]           pwdata_i,
  input  wire logic [31:0]           prdata_i,
  input  wire logic                  pready_i,
  // Request stream
  input  wire logic                  s_tvalid_i,
  input  wire logic                  s_tready_i,
  // tdata: src_addr, dst_addr, item_count, ctl_low, ctl_high, width_code
  input  wire logic [IN_DATA_W-1:0]  s_tdata_i,
  // Descriptor stream
  input  wire logic                  m_tvalid_i,
  input  wire logic                  m_tready_i,
  // tdata: desc_src, desc_dst, desc_ctl_low, desc_ctl_high, block_size_m1,
  //        next_ptr
  input  wire logic [OUT_DATA_W-1:0] m_tdata_i,
  input  wire logic                  m_tlast_i,
  // tuser: status
  input  wire logic [STAT_W-1:0]     m_tuser_i,
  output int                         fail_count_o,
  output int                         pending_o
);

  localparam int unsigned IN_ITEM_W = $bits(in_item_t);
  localparam logic [63:0] BLK64     = 64'(BLOCK_ITEMS);

  // One predicted descriptor
  typedef struct packed {
    status_e           status;
    logic [ADDR_W-1:0] src;
    logic [ADDR_W-1:0] dst;
    logic [CTL_W-1:0]  ctl_low;
    logic [CTL_W-1:0]  ctl_high;
    logic [BSM_W-1:0]  bsm1;
    logic [PTR_W-1:0]  next_ptr;
    logic              last;
  } chain_desc_t;

  chain_desc_t      desc_expected[$];
  logic [PTR_W-1:0] list_base = '0;
  int               mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  // Split one request into its descriptors and queue them in list order
  function automatic void build_chain(input in_item_t req);
    chain_desc_t d;
    logic [63:0] count, n_blocks, tail, src_step, dst_step, k, sum;
    d        = '0;
    count    = 64'(req.item_count);
    if (count == 0) begin
      d.status = STATUS_ZERO;
      d.last   = 1'b1;
      desc_expected.push_back(d);
      return;
    end
    n_blocks = (count + BLK64 - 1) / BLK64;
    if (n_blocks > MAX_DESC) begin
      d.status = STATUS_TOO_MANY;
      d.last   = 1'b1;
      desc_expected.push_back(d);
      return;
    end
    tail     = count % BLK64;
    src_step = req.ctl_low[SRC_FIX_BIT] ? 64'd0 : (BLK64 << req.width_code);
    dst_step = req.ctl_low[DST_FIX_BIT] ? 64'd0 : (BLK64 << req.width_code);
    for (k = 0; k < n_blocks; k++) begin
      d.status   = STATUS_OK;
      d.last     = (k + 1 == n_blocks);
      sum        = req.src_addr + src_step * k;
      d.src      = sum[ADDR_W-1:0];
      sum        = req.dst_addr + dst_step * k;
      d.dst      = sum[ADDR_W-1:0];
      d.ctl_low  = req.ctl_low;
      d.ctl_high = req.ctl_high | CTL_HI_VALID | (d.last ? CTL_HI_LAST : '0);
      sum        = (d.last && tail != 0) ? tail - 1 : BLK64 - 1;
      d.bsm1     = sum[BSM_W-1:0];
      sum        = list_base + (k + 1) * DESC_BYTES;
      d.next_ptr = d.last ? '0 : sum[PTR_W-1:0];
      desc_expected.push_back(d);
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] exp_v,
                                      input logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Track the register, compare descriptors, then predict new requests
  always @(posedge clk_i) begin : watch
    out_data_t   od;
    chain_desc_t want;
    if (!rst_ni) begin
      list_base = '0;
      desc_expected.delete();
    end else begin
      if (psel_i && penable_i && pready_i && paddr_i[2] == REG_LIST_BASE) begin
        if (pwrite_i) list_base = pwdata_i;
        else check_field("prdata", list_base, prdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (desc_expected.size() == 0) begin
          $error("descriptor item with no prediction waiting");
          mismatch_count++;
        end else begin
          want = desc_expected.pop_front();
          od   = m_tdata_i;
          check_field("status", want.status, m_tuser_i);
          check_field("desc_src", want.src, od.desc_src);
          check_field("desc_dst", want.dst, od.desc_dst);
          check_field("desc_ctl_low", want.ctl_low, od.desc_ctl_low);
          check_field("desc_ctl_high", want.ctl_high, od.desc_ctl_high);
          check_field("block_size_m1", want.bsm1, od.block_size_m1);
          check_field("next_ptr", want.next_ptr, od.next_ptr);
          check_field("last", want.last, m_tlast_i);
        end
      end
      if (s_tvalid_i && s_tready_i) build_chain(s_tdata_i[IN_ITEM_W-1:0]);
    end
    pending_o <= desc_expected.size();
  end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives the descriptor chain builder with directed and random transfer
// requests under several idle and stall patterns and list base settings;
// the checker beside the block predicts and compares every descriptor.
// ----------------------------------------------------------------------------

module tb_top;
  import dcb_pkg::*;

  localparam int unsigned IN_PAD_W     = IN_DATA_W - $bits(in_item_t);
  localparam int unsigned MAX_OK_COUNT = MAX_DESC_DEF * BLOCK_ITEMS_DEF;
  localparam int unsigned MAX_COUNT    = (1 << ITEM_W) - 1;
  localparam logic [2:0]  LIST_BASE_ADDR = {REG_LIST_BASE, 2'b00};
  localparam logic [2:0]  UNMAPPED_ADDR  = {~REG_LIST_BASE, 2'b00};
  localparam logic [CTL_W-1:0] SRC_FIX = 32'h1 << SRC_FIX_BIT;
  localparam logic [CTL_W-1:0] DST_FIX = 32'h1 << DST_FIX_BIT;
  localparam int unsigned ITEMS_PER_PHASE = 78;
  localparam int unsigned RX_HOLD_CYCLES  = 300;
  localparam int unsigned IDLE_TAIL       = 8;
  localparam int unsigned TIMEOUT_NS      = 5_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [2:0]            paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic [STAT_W-1:0]     m_axis_tuser;
  int                    fail_count;
  int                    pending;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold_req = 1'b0;
  logic        rx_hold_ack = 1'b0;
  int unsigned rx_hold_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  dma_descriptor_chain_builder i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  dcb_chain_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tlast_i    (m_axis_tlast),
    .m_tuser_i    (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Descriptor receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rx_hold_req != rx_hold_ack) begin
      rx_hold_ack   <= rx_hold_req;
      rx_hold_left  <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left  <= rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // Hard stop
  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  function automatic in_item_t make_req(input logic [31:0] src, input logic [31:0] dst,
                                        input logic [ITEM_W-1:0] count,
                                        input logic [CTL_W-1:0] clo,
                                        input logic [CTL_W-1:0] chi,
                                        input logic [WCODE_W-1:0] wcode);
    in_item_t req;
    req.src_addr   = src;
    req.dst_addr   = dst;
    req.item_count = count;
    req.ctl_low    = clo;
    req.ctl_high   = chi;
    req.width_code = wcode;
    return req;
  endfunction

  // Mostly legal lengths, with block edges, oversize and zero mixed in
  function automatic logic [ITEM_W-1:0] pick_count();
    int unsigned sel, k;
    sel = $urandom_range(99);
    k   = $urandom_range(MAX_DESC_DEF, 1);
    if (sel < 28) return ITEM_W'($urandom_range(64, 1));
    else if (sel < 43) return ITEM_W'($urandom_range(BLOCK_ITEMS_DEF, 1));
    else if (sel < 63) return ITEM_W'($urandom_range(MAX_OK_COUNT, 1));
    else if (sel < 83) return ITEM_W'(k * BLOCK_ITEMS_DEF + $urandom_range(2) - 1);
    else if (sel < 95) return ITEM_W'($urandom_range(MAX_COUNT, MAX_OK_COUNT + 1));
    else return '0;
  endfunction

  function automatic logic [31:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    else if (sel == 1) return '1;
    else return $urandom;
  endfunction

  function automatic in_item_t rand_req();
    return make_req(pick_word(), pick_word(), pick_count(), $urandom, pick_word(),
                    WCODE_W'($urandom_range(7)));
  endfunction

  // Offer one request and hold it until the block takes it
  task automatic send_req(input in_item_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{IN_PAD_W{1'b0}}, req};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drop the request valid and wait until every descriptor has come out
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Write the list base and read it back
  task automatic set_list_base(input logic [31:0] base);
    apb_access(1'b1, LIST_BASE_ADDR, base);
    apb_access(1'b0, LIST_BASE_ADDR, '0);
  endtask

  initial begin : stimulus
    int unsigned tx_tbl[4];
    int unsigned rx_tbl[4];
    logic [31:0] base_tbl[4];
    tx_tbl   = '{0, 56, 0, 9};
    rx_tbl   = '{0, 0, 56, 9};
    base_tbl = '{32'hFFFF_FFFF, 32'hFFFF_FFC0, $urandom, 32'h0000_0000};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests at the reset list base
    apb_access(1'b0, LIST_BASE_ADDR, '0);
    send_req(make_req('1, '1, '0, '1, '1, 3'd7));
    send_req(make_req('0, '0, 25'd1, '0, '0, 3'd0));
    send_req(make_req(32'h1000, 32'h2000, ITEM_W'(BLOCK_ITEMS_DEF - 1), '0, '0, 3'd0));
    send_req(make_req(32'h1000, 32'h2000, ITEM_W'(BLOCK_ITEMS_DEF), '0, '0, 3'd0));
    send_req(make_req(32'h1000, 32'h2000, ITEM_W'(BLOCK_ITEMS_DEF + 1), '0, '0, 3'd1));
    send_req(make_req('0, '0, ITEM_W'(2 * BLOCK_ITEMS_DEF - 1), '0, '1, 3'd2));
    send_req(make_req('1, '1, ITEM_W'(MAX_OK_COUNT), '0, '0, 3'd7));
    send_req(make_req('1, '1, ITEM_W'(MAX_OK_COUNT), SRC_FIX, '0, 3'd7));
    send_req(make_req(32'h8000_0000, 32'h4000_0000, ITEM_W'(MAX_OK_COUNT - 1),
                      DST_FIX, '0, 3'd3));
    send_req(make_req($urandom, $urandom, ITEM_W'(4 * BLOCK_ITEMS_DEF + 1), '1,
                      $urandom, 3'd5));
    send_req(make_req($urandom, $urandom, ITEM_W'(MAX_OK_COUNT + 1), $urandom,
                      $urandom, 3'd4));
    send_req(make_req('1, '1, ITEM_W'(MAX_COUNT), '1, '1, 3'd7));
    send_req(make_req($urandom, $urandom, ITEM_W'(3 * BLOCK_ITEMS_DEF),
                      ~(SRC_FIX | DST_FIX), 32'h3FFF_FFFF, 3'd6));
    send_req(make_req($urandom, $urandom, 25'd2, '0, '0, 3'd7));
    send_req(make_req($urandom, $urandom, '0, '0, '0, 3'd0));
    wait_idle();

    // Random phases, each with its own list base and idle pattern
    for (int p = 0; p < 4; p++) begin
      set_list_base(base_tbl[p]);
      if (p == 0) begin
        // a write to an unmapped register must leave the list base alone
        apb_access(1'b1, UNMAPPED_ADDR, 32'h5A5A_A5A5);
        apb_access(1'b0, LIST_BASE_ADDR, '0);
      end
      tx_idle_pct  =  tx_tbl[p];
      rx_stall_pct <= rx_tbl[p];
      if (p == 0) rx_hold_req <= ~rx_hold_req;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_req(rand_req());
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/dcb_pkg.sv
src/dcb_step_unit.sv
src/dma_descriptor_chain_builder.sv
tb/dcb_chain_checker.sv
tb/tb_top.sv
